// ----- rtl/core/tcp_socket_pair_table_unit_macros.svh -----
// Assertion macros for the connection table block
`ifndef TCP_SOCKET_PAIR_TABLE_UNIT_MACROS_SVH
`define TCP_SOCKET_PAIR_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define TSPT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tspt: assertion failed");

// next-cycle implication
`define TSPT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tspt: assertion failed");

`endif

// ----- rtl/core/tspt_pkg.sv -----
// Types, codes and defaults shared by the connection table modules
package tspt_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned PORT_SPAN_DEF   = 4096;

    localparam logic [15:0] EPH_FIRST_RST = 16'd1024;
    localparam logic [15:0] EPH_END_RST   = 16'd5000;
    localparam logic [6:0]  CNT_MAX       = 7'd127;

    localparam logic [2:0] OP_LOOKUP = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_UPDATE = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_ALLOC  = 3'd4;

    localparam logic [2:0] RS_OK        = 3'd0;
    localparam logic [2:0] RS_NOT_FOUND = 3'd1;
    localparam logic [2:0] RS_IN_USE    = 3'd2;
    localparam logic [2:0] RS_FULL      = 3'd3;
    localparam logic [2:0] RS_EXHAUSTED = 3'd4;
    localparam logic [2:0] RS_NO_HANDLE = 3'd5;

    localparam logic CFG_EPH_FIRST = 1'b0;
    localparam logic CFG_EPH_END   = 1'b1;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic        remote_port_any;
        logic [15:0] conn_handle;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_handle;
        logic [1:0]  match_level;
        logic [15:0] port_out;
    } t_rsp;

    typedef struct packed {
        logic [31:0] local_addr;
        logic [31:0] remote_addr;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic        remote_any;
        logic [15:0] handle;
    } t_entry;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN1,
        ST_EVAL1,
        ST_SCAN2,
        ST_EVAL2,
        ST_WRITE,
        ST_CNT_RD,
        ST_CNT_WR,
        ST_ALLOC_RD,
        ST_ALLOC_CHK,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       scan_start;
        logic       pass2;
        logic       scan_run;
        logic       ent_write;
        logic       clr_run;
        logic       cnt_rd;
        logic       cnt_wr;
        logic       alloc_init;
        logic       alloc_rd;
        logic       alloc_step;
        logic       alloc_take;
        logic       load_out;
        logic [2:0] rsp_status;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       scan_done;
        logic       lk_hit;
        logic       dup_hit;
        logic       free_hit;
        logic       h_hit;
        logic       span_zero;
        logic       alloc_zero;
        logic       alloc_last;
        logic [2:0] op;
    } t_sts;

endpackage

// ----- rtl/core/tcp_socket_pair_table_unit.sv -----
// Top level of the TCP connection table with wildcard lookup
//
// Request channel (i_in_valid/o_in_ready, i_in): one operation per request:
// lookup, add, update, remove or ephemeral port allocate. Response channel
// (o_out_valid/i_out_ready, o_out): exactly one response per request, in order.
// Configuration: i_cfg_wr_en writes i_cfg_data to ephemeral_first (index 0)
// or ephemeral_end (index 1); write only while idle.
// One request is handled at a time; the table is scanned one entry a cycle
// through the registered read of the entry store. States from acceptance to
// the response, after which the block returns to idle for the next request:
//   lookup, add-duplicate, add-full, handle miss: dispatch, scan, evaluate, response
//   add, remove: as above, plus entry write (clear for remove) and use-count read-modify-write
//   update: handle pass, then key pass, then entry write
//   allocate: a use-count read and check per probed port, at most span ports
// After reset the use-count store is swept to zero, all PORT_SPAN entries, with
// o_in_ready low. A finished response sits in the output register; a new
// request is taken while it waits, and a second finished response holds
// until the first has been taken.
`include "tcp_socket_pair_table_unit_macros.svh"

module tcp_socket_pair_table_unit #(
    parameter int unsigned TABLE_DEPTH = tspt_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned PORT_SPAN   = tspt_pkg::PORT_SPAN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tspt_pkg::t_req i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tspt_pkg::t_rsp o_out,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    import tspt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tspt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tspt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .PORT_SPAN   (PORT_SPAN)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    `TSPT_ASSERT_NXT(a_one_request, i_in_valid && o_in_ready, !o_in_ready)
    `TSPT_ASSERT_IMP(a_status_code, o_out_valid, o_out.status <= RS_NO_HANDLE)
    `TSPT_ASSERT_IMP(a_fail_clean, o_out_valid && (o_out.status != RS_OK), (o_out.found_handle == 16'd0) && (o_out.port_out == 16'd0) && (o_out.match_level == 2'd0))

endmodule

// ----- rtl/core/tspt_ctrl.sv -----
// Sequencing state machine for the connection table
module tspt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tspt_pkg::t_cmd  o_cmd,
    input  tspt_pkg::t_sts  i_sts
);
    import tspt_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_status, n_status;
    logic       r_out_vld, n_out_vld;
    logic       out_free;

    assign out_free    = !r_out_vld || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_status  <= RS_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_status  <= n_status;
            r_out_vld <= n_out_vld;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                case (i_sts.op)
                    OP_LOOKUP, OP_ADD, OP_UPDATE, OP_REMOVE: n_state = ST_SCAN1;
                    OP_ALLOC: begin
                        if (i_sts.span_zero) begin
                            n_status = RS_EXHAUSTED;
                            n_state  = ST_RESP;
                        end else begin
                            n_state = ST_ALLOC_RD;
                        end
                    end
                    default: begin
                        n_status = RS_NOT_FOUND;
                        n_state  = ST_RESP;
                    end
                endcase
            end
            ST_SCAN1: begin
                if (i_sts.scan_done) n_state = ST_EVAL1;
            end
            ST_EVAL1: begin
                case (i_sts.op)
                    OP_LOOKUP: begin
                        n_status = i_sts.lk_hit ? RS_OK : RS_NOT_FOUND;
                        n_state  = ST_RESP;
                    end
                    OP_ADD: begin
                        if (i_sts.dup_hit) begin
                            n_status = RS_IN_USE;
                            n_state  = ST_RESP;
                        end else if (!i_sts.free_hit) begin
                            n_status = RS_FULL;
                            n_state  = ST_RESP;
                        end else begin
                            n_status = RS_OK;
                            n_state  = ST_WRITE;
                        end
                    end
                    OP_UPDATE: begin
                        if (!i_sts.h_hit) begin
                            n_status = RS_NO_HANDLE;
                            n_state  = ST_RESP;
                        end else begin
                            n_state = ST_SCAN2;
                        end
                    end
                    OP_REMOVE: begin
                        if (!i_sts.h_hit) begin
                            n_status = RS_NO_HANDLE;
                            n_state  = ST_RESP;
                        end else begin
                            n_status = RS_OK;
                            n_state  = ST_WRITE;
                        end
                    end
                    default: begin
                        n_status = RS_NOT_FOUND;
                        n_state  = ST_RESP;
                    end
                endcase
            end
            ST_SCAN2: begin
                if (i_sts.scan_done) n_state = ST_EVAL2;
            end
            ST_EVAL2: begin
                if (i_sts.dup_hit) begin
                    n_status = RS_IN_USE;
                    n_state  = ST_RESP;
                end else begin
                    n_status = RS_OK;
                    n_state  = ST_WRITE;
                end
            end
            ST_WRITE: begin
                n_state = (i_sts.op == OP_UPDATE) ? ST_RESP : ST_CNT_RD;
            end
            ST_CNT_RD: n_state = ST_CNT_WR;
            ST_CNT_WR: n_state = ST_RESP;
            ST_ALLOC_RD: n_state = ST_ALLOC_CHK;
            ST_ALLOC_CHK: begin
                if (i_sts.alloc_zero) begin
                    n_status = RS_OK;
                    n_state  = ST_RESP;
                end else if (i_sts.alloc_last) begin
                    n_status = RS_EXHAUSTED;
                    n_state  = ST_RESP;
                end else begin
                    n_state = ST_ALLOC_RD;
                end
            end
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.rsp_status = r_status;
        case (r_state)
            ST_CLEAR: o_cmd.clr_run = 1'b1;
            ST_IDLE:  o_cmd.accept  = i_in_valid;
            ST_DISPATCH: begin
                o_cmd.scan_start = (i_sts.op == OP_LOOKUP) || (i_sts.op == OP_ADD) ||
                                   (i_sts.op == OP_UPDATE) || (i_sts.op == OP_REMOVE);
                o_cmd.alloc_init = (i_sts.op == OP_ALLOC);
            end
            ST_SCAN1, ST_SCAN2: o_cmd.scan_run = 1'b1;
            ST_EVAL1: begin
                o_cmd.scan_start = (i_sts.op == OP_UPDATE) && i_sts.h_hit;
                o_cmd.pass2      = 1'b1;
            end
            ST_WRITE:    o_cmd.ent_write = 1'b1;
            ST_CNT_RD:   o_cmd.cnt_rd    = 1'b1;
            ST_CNT_WR:   o_cmd.cnt_wr    = 1'b1;
            ST_ALLOC_RD: o_cmd.alloc_rd  = 1'b1;
            ST_ALLOC_CHK: begin
                o_cmd.alloc_take = i_sts.alloc_zero;
                o_cmd.alloc_step = !i_sts.alloc_zero && !i_sts.alloc_last;
            end
            ST_RESP: o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) n_out_vld = 1'b1;
        else if (i_out_ready) n_out_vld = 1'b0;
        else n_out_vld = r_out_vld;
    end

endmodule

// ----- rtl/core/tspt_dpath.sv -----
// Datapath: entry store, port use counts, scan compare and allocate walk
module tspt_dpath #(
    parameter int unsigned TABLE_DEPTH = tspt_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned PORT_SPAN   = tspt_pkg::PORT_SPAN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tspt_pkg::t_req i_in,
    output tspt_pkg::t_rsp o_out,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data,
    input  tspt_pkg::t_cmd i_cmd,
    output tspt_pkg::t_sts o_sts
);
    import tspt_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW = IW + 1;
    localparam int CW = $clog2(PORT_SPAN);
    localparam int SW = $clog2(PORT_SPAN + 1);

    // request and configuration
    t_req        req_in;
    t_req        r_req;
    logic [15:0] r_eph_first, r_eph_end, r_last_port, r_port;
    t_rsp        r_out;

    // entry store
    t_entry             ent_mem [TABLE_DEPTH];
    t_entry             r_rd_ent;
    logic [TABLE_DEPTH-1:0] r_valid;

    // scan
    logic [PW-1:0] r_idx;
    logic          r_pend, r_pass2;
    logic [IW-1:0] r_pidx;
    logic [3:0]    r_lvl_hit;
    logic [15:0]   r_lvl_h [4];
    logic          r_free_hit, r_h_hit;
    logic [IW-1:0] r_free_idx, r_h_idx;
    logic [15:0]   r_h_lp;

    // port use counts
    logic [6:0]    cnt_mem [PORT_SPAN];
    logic [6:0]    r_cnt_rd;
    logic [CW-1:0] r_clr_idx;
    logic [SW-1:0] r_cand, r_left;

    // wildcard remote port is held as zero
    always_comb begin
        req_in = i_in;
        if (i_in.remote_port_any) req_in.remote_port = 16'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_req <= req_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eph_first <= EPH_FIRST_RST;
            r_eph_end   <= EPH_END_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_EPH_FIRST: r_eph_first <= i_cfg_data;
                CFG_EPH_END:   r_eph_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // range span and offset of the port in hand
    logic [16:0]   diff17, span17, off17;
    logic [SW-1:0] span;
    logic [15:0]   port_sel;
    logic          off_ok;
    logic [CW-1:0] off;

    assign diff17 = {1'b0, r_eph_end} - {1'b0, r_eph_first};
    assign span17 = (r_eph_end <= r_eph_first) ? 17'd0 :
                    ((diff17 > 17'(PORT_SPAN)) ? 17'(PORT_SPAN) : diff17);
    assign span   = SW'(span17);

    always_comb begin
        case (r_req.opcode)
            OP_ADD:    port_sel = r_req.local_port;
            OP_REMOVE: port_sel = r_h_lp;
            default:   port_sel = r_last_port;
        endcase
    end

    assign off17  = {1'b0, port_sel} - {1'b0, r_eph_first};
    assign off_ok = (port_sel >= r_eph_first) && (off17 < span17);
    assign off    = CW'(off17);

    // scan compare on the registered read
    logic [15:0] key_lp;
    logic        v, skip, la_eq, la_z, ra_eq, ra_z, lp_eq, rs_eq, h_eq;
    logic [3:0]  m;

    assign key_lp = r_pass2 ? r_h_lp : r_req.local_port;
    assign v      = r_valid[r_pidx];
    assign skip   = r_pass2 && (r_pidx == r_h_idx);
    assign la_eq  = r_rd_ent.local_addr == r_req.local_addr;
    assign la_z   = r_rd_ent.local_addr == 32'd0;
    assign ra_eq  = r_rd_ent.remote_addr == r_req.remote_addr;
    assign ra_z   = r_rd_ent.remote_addr == 32'd0;
    assign lp_eq  = r_rd_ent.local_port == key_lp;
    assign rs_eq  = (r_rd_ent.remote_any == r_req.remote_port_any) &&
                    (r_req.remote_port_any || (r_rd_ent.remote_port == r_req.remote_port));
    assign h_eq   = r_rd_ent.handle == r_req.conn_handle;

    // levels: exact, no local address, no remote socket, neither
    assign m[0] = v && !skip && la_eq && ra_eq && lp_eq && rs_eq;
    assign m[1] = v && la_z && ra_eq && lp_eq && rs_eq;
    assign m[2] = v && la_eq && ra_z && lp_eq && r_rd_ent.remote_any;
    assign m[3] = v && la_z && ra_z && lp_eq && r_rd_ent.remote_any;

    logic issue;
    assign issue = i_cmd.scan_run && (r_idx < PW'(TABLE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_pass2 <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_pass2 <= i_cmd.pass2;
        end else if (issue) begin
            r_idx  <= r_idx + PW'(1);
            r_pend <= 1'b1;
        end else begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) r_pidx <= r_idx[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_lvl_hit  <= '0;
            r_free_hit <= 1'b0;
            if (!i_cmd.pass2) r_h_hit <= 1'b0;
        end else if (r_pend) begin
            for (int l = 0; l < 4; l++) begin
                if (m[l] && !r_lvl_hit[l]) begin
                    r_lvl_hit[l] <= 1'b1;
                    r_lvl_h[l]   <= r_rd_ent.handle;
                end
            end
            if (!v && !r_free_hit) begin
                r_free_hit <= 1'b1;
                r_free_idx <= r_pidx;
            end
            if (!r_pass2 && v && h_eq && !r_h_hit) begin
                r_h_hit <= 1'b1;
                r_h_idx <= r_pidx;
                r_h_lp  <= r_rd_ent.local_port;
            end
        end
    end

    // entry store ports
    logic          ent_we;
    logic [IW-1:0] ent_wa;
    t_entry        ent_wd;

    assign ent_we = i_cmd.ent_write && (r_req.opcode != OP_REMOVE);
    assign ent_wa = (r_req.opcode == OP_ADD) ? r_free_idx : r_h_idx;
    always_comb begin
        ent_wd.local_addr  = r_req.local_addr;
        ent_wd.remote_addr = r_req.remote_addr;
        ent_wd.local_port  = (r_req.opcode == OP_ADD) ? r_req.local_port : r_h_lp;
        ent_wd.remote_port = r_req.remote_port;
        ent_wd.remote_any  = r_req.remote_port_any;
        ent_wd.handle      = r_req.conn_handle;
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[ent_wa] <= ent_wd;
        if (issue) r_rd_ent <= ent_mem[r_idx[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.ent_write) begin
            case (r_req.opcode)
                OP_ADD:    r_valid[r_free_idx] <= 1'b1;
                OP_REMOVE: r_valid[r_h_idx]    <= 1'b0;
                default: ;
            endcase
        end
    end

    // use count store: clearing sweep, read-modify-write, allocate probe
    logic          cnt_we, cnt_re;
    logic [CW-1:0] cnt_wa, cnt_ra;
    logic [6:0]    cnt_wd;

    assign cnt_we = i_cmd.clr_run || (i_cmd.cnt_wr && off_ok);
    assign cnt_wa = i_cmd.clr_run ? r_clr_idx : off;
    assign cnt_re = i_cmd.cnt_rd || i_cmd.alloc_rd;
    assign cnt_ra = i_cmd.alloc_rd ? r_cand[CW-1:0] : off;

    always_comb begin
        if (i_cmd.clr_run) cnt_wd = 7'd0;
        else if (r_req.opcode == OP_ADD)
            cnt_wd = (r_cnt_rd == CNT_MAX) ? CNT_MAX : r_cnt_rd + 7'd1;
        else
            cnt_wd = (r_cnt_rd == 7'd0) ? 7'd0 : r_cnt_rd - 7'd1;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
        if (cnt_re) r_cnt_rd <= cnt_mem[cnt_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr_idx <= '0;
        else if (i_cmd.clr_run && (r_clr_idx != CW'(PORT_SPAN - 1))) r_clr_idx <= r_clr_idx + CW'(1);
    end

    // allocate walk
    logic [SW-1:0] start, nxt0, nxt;
    assign start = off_ok ? SW'(off17) : span - SW'(1);
    assign nxt0  = start + SW'(1);
    assign nxt   = r_cand + SW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_init) begin
            r_cand <= (nxt0 == span) ? '0 : nxt0;
            r_left <= span;
        end else if (i_cmd.alloc_step) begin
            r_cand <= (nxt == span) ? '0 : nxt;
            r_left <= r_left - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_last_port <= EPH_FIRST_RST;
        else if (i_cmd.alloc_take) r_last_port <= r_eph_first + 16'(r_cand);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_take) r_port <= r_eph_first + 16'(r_cand);
    end

    // result register
    logic [1:0]  sel_lvl;
    logic [15:0] sel_h;
    logic        rsp_ok;

    always_comb begin
        if (r_lvl_hit[0])      sel_lvl = 2'd0;
        else if (r_lvl_hit[1]) sel_lvl = 2'd1;
        else if (r_lvl_hit[2]) sel_lvl = 2'd2;
        else                   sel_lvl = 2'd3;
        sel_h = r_lvl_h[sel_lvl];
    end

    assign rsp_ok = (i_cmd.rsp_status == RS_OK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status       <= i_cmd.rsp_status;
            r_out.found_handle <= (rsp_ok && r_req.opcode == OP_LOOKUP) ? sel_h : 16'd0;
            r_out.match_level  <= (rsp_ok && r_req.opcode == OP_LOOKUP) ? sel_lvl : 2'd0;
            r_out.port_out     <= (rsp_ok && r_req.opcode == OP_ALLOC) ? r_port : 16'd0;
        end
    end

    assign o_out = r_out;

    always_comb begin
        o_sts.clr_done   = (r_clr_idx == CW'(PORT_SPAN - 1));
        o_sts.scan_done  = r_pend && (r_pidx == IW'(TABLE_DEPTH - 1));
        o_sts.lk_hit     = |r_lvl_hit;
        o_sts.dup_hit    = r_lvl_hit[0];
        o_sts.free_hit   = r_free_hit;
        o_sts.h_hit      = r_h_hit;
        o_sts.span_zero  = (span17 == 17'd0);
        o_sts.alloc_zero = (r_cnt_rd == 7'd0);
        o_sts.alloc_last = (r_left == SW'(1));
        o_sts.op         = r_req.opcode;
    end

endmodule
